>>> hw/rtl/chrl_pkg.sv
// shared types and codes for the consistent hash ring lookup block
`timescale 1ns / 1ps
`default_nettype none

package chrl_pkg;

    // field widths fixed by the stream format
    localparam int HASH_W   = 32;
    localparam int SID_W    = 8;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 7;

    // request modes
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // insert broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [HASH_W-1:0] key;
        logic [SID_W-1:0]  server;
    } ins_req_t;

    // lookup token that walks the cell chain
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] key;
        logic              found;
        logic [SID_W-1:0]  server;
        logic              empty;
    } token_t;

endpackage

`default_nettype wire

>>> hw/rtl/chrl_cell.sv
// one ring cell: a sorted entry plus one stage of the lookup token path
`timescale 1ns / 1ps
`default_nettype none

module chrl_cell
    import chrl_pkg::*;
#(
    parameter int STORE_W = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic                valid,
    input  wire ins_req_t            ins,
    input  wire logic                shift_in,
    input  wire logic [HASH_W-1:0]   prev_hash,
    input  wire logic [STORE_W-1:0]  prev_server,
    output logic                     shift_out,
    output logic [HASH_W-1:0]        hash_out,
    output logic [STORE_W-1:0]       server_out,
    input  wire token_t              tok_in,
    output token_t                   tok_out
);

    logic [HASH_W-1:0]  hash_reg;
    logic [HASH_W-1:0]  hash_next;
    logic [STORE_W-1:0] server_reg;
    logic [STORE_W-1:0] server_next;
    token_t             tok_reg;
    token_t             tok_next;
    logic               gt_tok;

    // this cell or an empty slot is at or past the insert position
    assign shift_out = !valid || (hash_reg > ins.key);

    // entry update: move up from the lower neighbor or take the new entry
    always_comb
    begin
        hash_next   = hash_reg;
        server_next = server_reg;
        if (ins.en)
        begin
            priority if (shift_in)
            begin
                hash_next   = prev_hash;
                server_next = prev_server;
            end
            else if (shift_out)
            begin
                hash_next   = ins.key;
                server_next = ins.server[STORE_W-1:0];
            end
            else
            begin
                // below the insert position the entry stays put
                hash_next   = hash_reg;
                server_next = server_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg   <= hash_next;
        server_reg <= server_next;
    end

    // lookup stage: first cell above the key claims the token
    assign gt_tok = valid && (hash_reg > tok_in.key);

    always_comb
    begin
        tok_next       = tok_in;
        tok_next.found = tok_in.found || gt_tok;
        if (gt_tok && !tok_in.found)
        begin
            tok_next.server = SID_W'(server_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign hash_out   = hash_reg;
    assign server_out = server_reg;
    assign tok_out    = tok_reg;

endmodule

`default_nettype wire

>>> hw/rtl/chrl_ring.sv
// chain of ring cells kept in ascending hash order
`timescale 1ns / 1ps
`default_nettype none

module chrl_ring
    import chrl_pkg::*;
#(
    parameter int RING_SLOTS     = 64,
    parameter int SERVER_ID_BITS = 8,
    parameter int CNT_W          = $clog2(RING_SLOTS + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [CNT_W-1:0]  count,
    input  wire ins_req_t          ins,
    input  wire token_t            tok_in,
    output token_t                 tok_out,
    output logic [SID_W-1:0]       head_server
);

    localparam int STORE_W = (SERVER_ID_BITS < SID_W) ? SERVER_ID_BITS : SID_W;

    logic [RING_SLOTS-1:0] shift;
    logic [HASH_W-1:0]     hash  [RING_SLOTS];
    logic [STORE_W-1:0]    srv   [RING_SLOTS];
    token_t                tok   [RING_SLOTS];

    // cell zero has no lower neighbor
    chrl_cell #(
        .STORE_W (STORE_W)
    ) u_cell_0 (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .valid       (count != '0),
        .ins         (ins),
        .shift_in    (1'b0),
        .prev_hash   ('0),
        .prev_server ('0),
        .shift_out   (shift[0]),
        .hash_out    (hash[0]),
        .server_out  (srv[0]),
        .tok_in      (tok_in),
        .tok_out     (tok[0])
    );

    // remaining cells take data from the cell below
    for (genvar i = 1; i < RING_SLOTS; i++)
    begin : g_cell
        chrl_cell #(
            .STORE_W (STORE_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .valid       (count > CNT_W'(i)),
            .ins         (ins),
            .shift_in    (shift[i-1]),
            .prev_hash   (hash[i-1]),
            .prev_server (srv[i-1]),
            .shift_out   (shift[i]),
            .hash_out    (hash[i]),
            .server_out  (srv[i]),
            .tok_in      (tok[i-1]),
            .tok_out     (tok[i])
        );
    end

    assign tok_out     = tok[RING_SLOTS-1];
    assign head_server = SID_W'(srv[0]);

endmodule

`default_nettype wire

>>> hw/rtl/consistent_hash_ring_lookup_core.sv
// consistent hash ring: sorted virtual-node store with server lookup
//
// requests arrive on the s_ stream (tuser = mode, tdata = hash, server id)
// and each yields exactly one result on the m_ stream, in request order.
// clear, insert and the unused mode need no token walk: while nothing
// stalls one request can be accepted every cycle, its result passing the
// holding register and then the output register. a lookup token walks
// the row of RING_SLOTS cells, one cell per cycle while the output is not
// stalled, each cell comparing the key with its own entry; lookups stream
// at one per cycle under that condition. a clear or insert after lookups
// waits until the cell row has drained, and a lookup never waits behind an insert.
// the input holding register and the output register keep both sides
// decoupled; while a result waits on low m_tready the cell row and output
// freeze, and s_tready drops once the holding register is full.
// reset empties the ring and drops any request in flight; entries need
// no clearing pass since only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module consistent_hash_ring_lookup_core
    import chrl_pkg::*;
#(
    parameter int RING_SLOTS     = 64,
    parameter int SERVER_ID_BITS = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // hash_value[31:0], server_id[39:32]
    input  wire logic [1:0]   s_tuser,   // mode[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata,   // chosen_server[7:0], entries_held[14:8], zero
    output logic [1:0]        m_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(RING_SLOTS + 1);

    logic                hold_valid_reg, hold_valid_next;
    logic [MODE_W-1:0]   hold_mode_reg;
    logic [HASH_W-1:0]   hold_hash_reg;
    logic [SID_W-1:0]    hold_sid_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    inflight_reg, inflight_next;
    logic                out_valid_reg, out_valid_next;
    logic [SID_W-1:0]    out_server_reg, out_server_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [HELD_W-1:0]   out_held_reg, out_held_next;

    logic       accept;
    logic       advance;
    logic       is_lookup;
    logic       dispatch;
    logic       launch;
    logic       retire;
    logic       full;
    ins_req_t   ins;
    token_t     tok_entry;
    token_t     tok_exit;
    logic [SID_W-1:0] head_server;

    // handshake and dispatch control
    assign advance   = !out_valid_reg || m_tready;
    assign is_lookup = (hold_mode_reg == MODE_LOOKUP);
    assign dispatch  = hold_valid_reg && advance && (is_lookup || (inflight_reg == '0));
    assign launch    = dispatch && is_lookup;
    assign retire    = advance && tok_exit.valid;
    assign s_tready  = !hold_valid_reg || dispatch;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(RING_SLOTS));

    // input holding register
    assign hold_valid_next = accept ? 1'b1 : (dispatch ? 1'b0 : hold_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_mode_reg <= s_tuser;
            hold_hash_reg <= s_tdata[31:0];
            hold_sid_reg  <= s_tdata[39:32];
        end
    end

    // insert broadcast and lookup token launch
    assign ins.en     = dispatch && (hold_mode_reg == MODE_INSERT) && !full;
    assign ins.key    = hold_hash_reg;
    assign ins.server = hold_sid_reg;

    assign tok_entry.valid  = launch;
    assign tok_entry.key    = hold_hash_reg;
    assign tok_entry.found  = 1'b0;
    assign tok_entry.server = head_server;
    assign tok_entry.empty  = (count_reg == '0);

    chrl_ring #(
        .RING_SLOTS     (RING_SLOTS),
        .SERVER_ID_BITS (SERVER_ID_BITS),
        .CNT_W          (CNT_W)
    ) u_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .count       (count_reg),
        .ins         (ins),
        .tok_in      (tok_entry),
        .tok_out     (tok_exit),
        .head_server (head_server)
    );

    // lookups in the cell row
    always_comb
    begin
        unique case ({launch, retire})
            2'b10:   inflight_next = inflight_reg + CNT_W'(1);
            2'b01:   inflight_next = inflight_reg - CNT_W'(1);
            default: inflight_next = inflight_reg;
        endcase
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (dispatch)
        begin
            unique case (hold_mode_reg)
                MODE_CLEAR:  count_next = '0;
                MODE_INSERT: count_next = full ? count_reg : count_reg + CNT_W'(1);
                default:     count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            inflight_reg <= inflight_next;
        end
    end

    // output register: lookup token leaving the row or an immediate result
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_server_next = out_server_reg;
        out_status_next = out_status_reg;
        out_held_next   = out_held_reg;
        if (advance)
        begin
            out_valid_next = 1'b0;
            priority if (tok_exit.valid)
            begin
                out_valid_next  = 1'b1;
                out_server_next = tok_exit.empty ? '0 : tok_exit.server;
                out_status_next = tok_exit.empty ? STATUS_EMPTY : STATUS_OK;
                out_held_next   = HELD_W'(count_reg);
            end
            else if (dispatch && !is_lookup)
            begin
                out_valid_next  = 1'b1;
                out_server_next = '0;
                out_status_next = (ins.en || (hold_mode_reg != MODE_INSERT)) ?
                                  STATUS_OK : STATUS_FULL;
                out_held_next   = HELD_W'(count_next);
            end
            else
            begin
                // nothing ready this cycle
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_server_reg <= out_server_next;
        out_status_reg <= out_status_next;
        out_held_reg   <= out_held_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_held_reg, out_server_reg};
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

>>> hw/rtl/chrl_checker.sv
// port-level checks for the hash ring core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module chrl_checker
    import chrl_pkg::*;
#(
    parameter int RING_SLOTS = 64
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [15:0]  m_tdata,
    input  wire logic [1:0]   m_tuser
);

    localparam logic [HELD_W-1:0] FULL_HELD = HELD_W'(RING_SLOTS);
    localparam bit                HELD_WRAPS = (RING_SLOTS > 127);

    logic [31:0] pending_reg;
    logic [31:0] pending_next;

    // requests taken but not yet answered
    assign pending_next = pending_reg + 32'(s_tvalid && s_tready)
                          - 32'(m_tvalid && m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // dropped inserts and empty lookups select no server
    a_err_no_server: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata[7:0] == 8'd0))
        else $error("server reported with an error status");

    // a full-ring drop reports a full ring
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_FULL) |-> (m_tdata[14:8] == FULL_HELD))
        else $error("full status with entries below capacity");

    // entry count never passes the capacity
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> HELD_WRAPS || (m_tdata[14:8] <= FULL_HELD))
        else $error("entry count above capacity");

    // a result only ever answers a request still owed
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pending_reg != '0))
        else $error("result without a request");

endmodule

bind consistent_hash_ring_lookup_core chrl_checker #(
    .RING_SLOTS (RING_SLOTS)
) u_chrl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
